### rtl/flrr_pkg.sv
`timescale 1ns / 1ps
package flrr_pkg;
   localparam logic [2:0] OP_LINE  = 3'd0;
   localparam logic [2:0] OP_RECT  = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_FLUSH = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   localparam logic [1:0] ROP_SET = 2'd0;
   localparam logic [1:0] ROP_XOR = 2'd1;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] x_first;
      logic [7:0] y_first;
      logic [7:0] x_second;
      logic [7:0] y_second;
      logic [7:0] rect_width;
      logic [7:0] rect_height;
      logic [1:0] raster_op;
      logic [2:0] read_page;
      logic [6:0] read_column;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
      logic       dirty_found;
      logic [2:0] dirty_page;
      logic [6:0] dirty_left;
      logic [6:0] dirty_right;
      logic [7:0] column_address;
   } rsp_type;
endpackage

### rtl/framebuffer_line_rect_rasterizer_core.sv
`timescale 1ns / 1ps
// Page-organized monochrome framebuffer with line/rectangle rasterizer.
// Channels: req_ (command transaction in), rsp_ (one result transaction
// per command out), both valid/stall.
// One command is worked at a time; req_stall is high from acceptance
// until the result is registered in the output stage.
// An invalid or no-op command goes straight to the output stage, a read
// passes the read and read-data states, flush scans one page per cycle,
// and clear sweeps all 2**(page bits + column bits) store addresses.
// A line or rectangle takes each pixel through the address, fetch,
// modify-write and step states on the single store port and one shared
// error/step unit; the largest outline has 380 pixels.
// Reset acts as clear: the store is zeroed by the sweep before the first
// command is accepted, and every page is marked fully dirty.
// When the receiver stalls the result holds in rsp_; a new command is still
// accepted, but its result waits in the output state until that one is taken.
module framebuffer_line_rect_rasterizer_core #(
   parameter int COLUMN_COUNT = 128,
   parameter int PAGE_COUNT   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  flrr_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output flrr_pkg::rsp_type  rsp_data
);
   localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int CW = $clog2(COLUMN_COUNT);
   localparam int AW = PW + CW;
   localparam int ROWS = PAGE_COUNT * 8;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SETUP, S_PIX, S_FETCH, S_RMW, S_STEP, S_FLUSH, S_READ, S_READ2,
      S_OUT
   } state_type;

   state_type state_ff;
   flrr_pkg::req_type cmd_ff;
   flrr_pkg::rsp_type rsp_ff;
   flrr_pkg::rsp_type rsp_data_ff;
   logic rsp_valid_ff;
   logic [AW:0] clr_ff;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_ff;
   logic [AW-1:0] addr_ff;
   logic we;
   logic [7:0] wdata;

   logic [CW-1:0] dl_ff [PAGE_COUNT];
   logic [CW-1:0] dr_ff [PAGE_COUNT];

   // shared stepping state: line (u,v,err) or rect sequence
   logic [8:0] u_ff, u1_ff, v_ff;
   logic signed [9:0] err_ff;
   logic [8:0] du_ff, dv_ff;
   logic steep_ff, vneg_ff;
   logic [1:0] phase_ff;   // rect: 0 top, 1 bottom, 2 left, 3 right
   logic [8:0] px_ff, py_ff;
   logic [4:0] pg_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr_ff] <= wdata;
      rd_ff <= mem[addr_ff];
   end

   logic [7:0] mask;
   assign mask = 8'(1) << py_ff[2:0];
   always_comb begin
      we = 1'b0;
      wdata = (cmd_ff.raster_op == flrr_pkg::ROP_SET) ? (rd_ff | mask) : (rd_ff ^ mask);
      if (state_ff == S_CLEAR) begin
         we = 1'b1;
         wdata = '0;
      end else if (state_ff == S_RMW) begin
         we = 1'b1;
      end
   end

   logic [8:0] xa, ya, xb, yb, ax_d, ay_d;
   logic inr_line, inr_rect, inr_read;
   always_comb begin
      xa = {1'b0, req_data.x_first};
      ya = {1'b0, req_data.y_first};
      xb = {1'b0, req_data.x_second};
      yb = {1'b0, req_data.y_second};
      ax_d = xa + {1'b0, req_data.rect_width};
      ay_d = ya + {1'b0, req_data.rect_height};
      inr_line = (xa < 9'(COLUMN_COUNT)) && (ya < 9'(ROWS)) &&
                 (xb < 9'(COLUMN_COUNT)) && (yb < 9'(ROWS));
      inr_rect = (xa < 9'(COLUMN_COUNT)) && (ya < 9'(ROWS)) &&
                 (ax_d < 9'(COLUMN_COUNT)) && (ay_d < 9'(ROWS));
      inr_read = ({2'b0, req_data.read_page} < 5'(PAGE_COUNT)) &&
                 ({1'b0, req_data.read_column} < 8'(COLUMN_COUNT));
   end

   flrr_pkg::rsp_type rsp_init;
   always_comb begin
      rsp_init = '0;
      unique case (req_data.opcode)
         flrr_pkg::OP_LINE:  rsp_init.status = !inr_line;
         flrr_pkg::OP_RECT:  rsp_init.status = !inr_rect;
         flrr_pkg::OP_CLEAR: rsp_init.status = 1'b0;
         flrr_pkg::OP_FLUSH: rsp_init.status = 1'b0;
         flrr_pkg::OP_READ:  rsp_init.status = !inr_read;
         default:            rsp_init.status = 1'b1;
      endcase
   end

   // rect edge endpoints from stored command
   logic [8:0] rl, rt, rr, rb;
   assign rl = {1'b0, cmd_ff.x_first};
   assign rt = {1'b0, cmd_ff.y_first};
   assign rr = rl + {1'b0, cmd_ff.rect_width};
   assign rb = rt + {1'b0, cmd_ff.rect_height};

   logic [PW-1:0] ppg;
   logic [CW-1:0] pcol;
   assign ppg = PW'(py_ff[8:3]);
   assign pcol = CW'(px_ff);

   logic signed [9:0] err_n;
   assign err_n = err_ff - $signed({1'b0, dv_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         addr_ff <= '0;
         pg_ff <= '0;
         for (int p = 0; p < PAGE_COUNT; p++) begin
            dl_ff[p] <= '0;
            dr_ff[p] <= CW'(COLUMN_COUNT - 1);
         end
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               addr_ff <= AW'(clr_ff + 1'b1);
               clr_ff <= (clr_ff == (AW+1)'(DEPTH - 1)) ? '0 : clr_ff + 1'b1;
               if (clr_ff == (AW+1)'(DEPTH - 1)) begin
                  for (int p = 0; p < PAGE_COUNT; p++) begin
                     dl_ff[p] <= '0;
                     dr_ff[p] <= CW'(COLUMN_COUNT - 1);
                  end
                  state_ff <= (cmd_ff.opcode == flrr_pkg::OP_CLEAR && rsp_ff.status == 1'b0
                               && pg_ff == 5'd1) ? S_OUT : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_data;
                  rsp_ff <= rsp_init;
                  pg_ff <= (req_data.opcode == flrr_pkg::OP_CLEAR) ? 5'd1 : 5'd0;
                  unique case (req_data.opcode)
                     flrr_pkg::OP_LINE: begin
                        if (!inr_line || req_data.raster_op > flrr_pkg::ROP_XOR) begin
                           state_ff <= S_OUT;
                        end else state_ff <= S_SETUP;
                     end
                     flrr_pkg::OP_RECT: begin
                        if (!inr_rect || req_data.raster_op > flrr_pkg::ROP_XOR) begin
                           state_ff <= S_OUT;
                        end else state_ff <= S_SETUP;
                     end
                     flrr_pkg::OP_CLEAR: begin
                        clr_ff <= '0;
                        addr_ff <= '0;
                        state_ff <= S_CLEAR;
                     end
                     flrr_pkg::OP_FLUSH: state_ff <= S_FLUSH;
                     flrr_pkg::OP_READ: begin
                        if (!inr_read) begin
                           state_ff <= S_OUT;
                        end else begin
                           addr_ff <= {PW'(req_data.read_page), CW'(req_data.read_column)};
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_SETUP: begin
               if (cmd_ff.opcode == flrr_pkg::OP_RECT) begin
                  phase_ff <= 2'd0;
                  px_ff <= rl;
                  py_ff <= rt;
                  state_ff <= S_PIX;
               end else begin : ln
                  logic [8:0] du, dv;
                  logic st;
                  logic [8:0] u0, v0, u1, v1;
                  du = (cmd_ff.x_first > cmd_ff.x_second) ?
                       9'(cmd_ff.x_first - cmd_ff.x_second) : 9'(cmd_ff.x_second - cmd_ff.x_first);
                  dv = (cmd_ff.y_first > cmd_ff.y_second) ?
                       9'(cmd_ff.y_first - cmd_ff.y_second) : 9'(cmd_ff.y_second - cmd_ff.y_first);
                  st = dv > du;
                  if (st) begin
                     u0 = {1'b0, cmd_ff.y_first}; v0 = {1'b0, cmd_ff.x_first};
                     u1 = {1'b0, cmd_ff.y_second}; v1 = {1'b0, cmd_ff.x_second};
                     du_ff <= dv; dv_ff <= du;
                     err_ff <= $signed({2'b0, dv[8:1]});
                  end else begin
                     u0 = {1'b0, cmd_ff.x_first}; v0 = {1'b0, cmd_ff.y_first};
                     u1 = {1'b0, cmd_ff.x_second}; v1 = {1'b0, cmd_ff.y_second};
                     du_ff <= du; dv_ff <= dv;
                     err_ff <= $signed({2'b0, du[8:1]});
                  end
                  steep_ff <= st;
                  if (u0 > u1) begin
                     u_ff <= u1; v_ff <= v1; u1_ff <= u0; vneg_ff <= !(v0 > v1);
                     px_ff <= st ? v1 : u1; py_ff <= st ? u1 : v1;
                  end else begin
                     u_ff <= u0; v_ff <= v0; u1_ff <= u1; vneg_ff <= !(v1 > v0);
                     px_ff <= st ? v0 : u0; py_ff <= st ? u0 : v0;
                  end
                  state_ff <= S_PIX;
               end
            end
            S_PIX: begin
               addr_ff <= {ppg, pcol};
               state_ff <= S_FETCH;
            end
            S_FETCH: state_ff <= S_RMW;
            S_RMW: begin
               if (dl_ff[ppg] > pcol) dl_ff[ppg] <= pcol;
               if (dr_ff[ppg] < pcol) dr_ff[ppg] <= pcol;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               if (cmd_ff.opcode == flrr_pkg::OP_RECT) begin
                  unique case (phase_ff)
                     2'd0: begin
                        py_ff <= rb;
                        phase_ff <= 2'd1;
                        state_ff <= S_PIX;
                     end
                     2'd1: begin
                        if (px_ff == rr) begin
                           if (rt + 9'd1 < rb) begin
                              phase_ff <= 2'd2; px_ff <= rl; py_ff <= rt + 9'd1;
                              state_ff <= S_PIX;
                           end else state_ff <= S_OUT;
                        end else begin
                           phase_ff <= 2'd0; px_ff <= px_ff + 9'd1; py_ff <= rt;
                           state_ff <= S_PIX;
                        end
                     end
                     2'd2: begin
                        phase_ff <= 2'd3; px_ff <= rr;
                        state_ff <= S_PIX;
                     end
                     default: begin
                        if (py_ff + 9'd1 < rb) begin
                           phase_ff <= 2'd2; px_ff <= rl; py_ff <= py_ff + 9'd1;
                           state_ff <= S_PIX;
                        end else state_ff <= S_OUT;
                     end
                  endcase
               end else begin : lstep
                  logic [8:0] vn;
                  logic signed [9:0] en;
                  vn = v_ff;
                  en = err_n;
                  if (err_n < 0) begin
                     vn = vneg_ff ? v_ff - 9'd1 : v_ff + 9'd1;
                     en = err_n + $signed({1'b0, du_ff});
                  end
                  v_ff <= vn;
                  err_ff <= en;
                  u_ff <= u_ff + 9'd1;
                  px_ff <= steep_ff ? vn : u_ff + 9'd1;
                  py_ff <= steep_ff ? u_ff + 9'd1 : vn;
                  state_ff <= (u_ff == u1_ff) ? S_OUT : S_PIX;
               end
            end
            S_FLUSH: begin
               if (dl_ff[PW'(pg_ff)] <= dr_ff[PW'(pg_ff)]) begin
                  rsp_ff.dirty_found <= 1'b1;
                  rsp_ff.dirty_page <= 3'(pg_ff);
                  rsp_ff.dirty_left <= 7'(dl_ff[PW'(pg_ff)]);
                  rsp_ff.dirty_right <= 7'(dr_ff[PW'(pg_ff)]);
                  rsp_ff.column_address <= 8'(dl_ff[PW'(pg_ff)]) + 8'd2;
                  dl_ff[PW'(pg_ff)] <= CW'(COLUMN_COUNT - 1);
                  dr_ff[PW'(pg_ff)] <= '0;
                  state_ff <= S_OUT;
               end else if (pg_ff == 5'(PAGE_COUNT - 1)) state_ff <= S_OUT;
               else pg_ff <= pg_ff + 5'd1;
            end
            S_READ: state_ff <= S_READ2;
            S_READ2: begin
               rsp_ff.read_data <= rd_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff <= rsp_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
endmodule
